// File: design/redundant_frame_duplicate_discard_macros.svh
// assertion helpers used by rfdd_back
`ifndef REDUNDANT_FRAME_DUPLICATE_DISCARD_MACROS_SVH
`define REDUNDANT_FRAME_DUPLICATE_DISCARD_MACROS_SVH

// property checked on every clock edge outside reset
`define RFDD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define RFDD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rfdd_pkg.sv
`default_nettype none
package rfdd_pkg;

  localparam int NODES       = 8;
  localparam int MAX_BLOCKS  = 16;
  localparam int BLOCK_SHIFT = 7;
  localparam int SEQ_PORTS   = 4;

  localparam int SEQ_W       = 16;
  localparam int REC_W       = 2;
  localparam int STAMP_W     = 32;
  localparam int EXP_W       = 16;
  localparam int TAG_W       = SEQ_W - BLOCK_SHIFT;
  localparam int BLOCK_BITS  = 1 << BLOCK_SHIFT;
  localparam int NODE_W      = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int BLK_W       = $clog2(MAX_BLOCKS);
  localparam int SLOT_COUNT  = NODES * MAX_BLOCKS;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int ENT_W       = TAG_W + STAMP_W;
  localparam int ROW_W       = MAX_BLOCKS * ENT_W;
  localparam int SEEN_W      = SEQ_PORTS * BLOCK_BITS;
  localparam int SEEN_IW     = $clog2(SEEN_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // input func codes
  localparam logic [1:0] FUNC_CHECK = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // register indexes
  localparam logic REG_PRP_MODE = 1'b0;
  localparam logic REG_EXPIRY   = 1'b1;
  localparam logic [EXP_W-1:0] EXPIRY_RESET = 16'd400;

  typedef enum logic [1:0] {
    CMD_CHECK,
    CMD_TICK,
    CMD_CLEAR,
    CMD_PASS
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [NODE_W-1:0]      node;
    logic [TAG_W-1:0]       tag;
    logic [BLOCK_SHIFT-1:0] bit_idx;
    logic [REC_W-1:0]       rec;
    logic                   discard;
    logic                   bad_port;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK,
    BK_BITS
  } back_state_e;

endpackage
`default_nettype wire

// File: design/rfdd_ram.sv
`default_nettype none
module rfdd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: design/rfdd_front.sv
`default_nettype none
module rfdd_front (
  input  wire logic                  prp_mode_i,
  input  wire logic [1:0]            func_i,
  input  wire logic [2:0]            node_index_i,
  input  wire logic [15:0]           sequence_nr_i,
  input  wire logic [1:0]            out_port_i,
  input  wire logic                  rx_from_master_i,
  input  wire logic                  out_is_master_i,
  output rfdd_pkg::cmd_t             cmd_o
);

  logic node_ok;
  logic port_bad;

  assign node_ok  = 32'(node_index_i) < 32'(rfdd_pkg::NODES);
  assign port_bad = 32'(out_port_i) >= 32'(rfdd_pkg::SEQ_PORTS);

  // classify the beat into a back-end command
  always_comb begin
    cmd_o          = '0;
    cmd_o.kind     = rfdd_pkg::CMD_PASS;
    cmd_o.node     = rfdd_pkg::NODE_W'(node_index_i);
    cmd_o.tag      = sequence_nr_i[rfdd_pkg::SEQ_W-1:rfdd_pkg::BLOCK_SHIFT];
    cmd_o.bit_idx  = sequence_nr_i[rfdd_pkg::BLOCK_SHIFT-1:0];
    cmd_o.rec      = out_port_i;
    priority if (func_i == rfdd_pkg::FUNC_TICK) begin
      cmd_o.kind = rfdd_pkg::CMD_TICK;
    end else if (func_i == rfdd_pkg::FUNC_CLEAR && node_ok) begin
      cmd_o.kind = rfdd_pkg::CMD_CLEAR;
    end else if (func_i == rfdd_pkg::FUNC_CHECK && node_ok) begin
      if (prp_mode_i) begin
        // prp: frames from master pass, non-master outputs drop, master outputs are checked
        cmd_o.rec = '0;
        if (rx_from_master_i) begin
          cmd_o.discard = 1'b0;
        end else if (!out_is_master_i) begin
          cmd_o.discard = 1'b1;
        end else begin
          cmd_o.kind = rfdd_pkg::CMD_CHECK;
        end
      end else if (port_bad) begin
        cmd_o.bad_port = 1'b1;
      end else begin
        cmd_o.kind = rfdd_pkg::CMD_CHECK;
      end
    end else begin
      cmd_o.kind = rfdd_pkg::CMD_PASS;
    end
  end

endmodule
`default_nettype wire

// File: design/rfdd_queue.sv
`default_nettype none
module rfdd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  rfdd_pkg::cmd_t      in_cmd_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output rfdd_pkg::cmd_t      out_cmd_o
);

  rfdd_pkg::cmd_t                 buf_q [rfdd_pkg::QUEUE_DEPTH];
  logic                           wr_ptr_q, rd_ptr_q;
  logic [rfdd_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  logic                           push, pop;

  assign in_ready_o  = cnt_q != rfdd_pkg::QCNT_W'(rfdd_pkg::QUEUE_DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign out_cmd_o   = buf_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // fill level
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_cmd_i;
    end
  end

endmodule
`default_nettype wire

// File: design/rfdd_back.sv
`default_nettype none
`include "redundant_frame_duplicate_discard_macros.svh"
module rfdd_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [rfdd_pkg::EXP_W-1:0]   expiry_i,
  input  wire logic                         q_valid_i,
  output logic                              q_ready_o,
  input  rfdd_pkg::cmd_t                    q_cmd_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              discard_o,
  output logic                              bad_port_o
);

  localparam int NW = rfdd_pkg::NODE_W;
  localparam int BW = rfdd_pkg::BLK_W;
  localparam int SW = rfdd_pkg::SLOT_W;

  rfdd_pkg::back_state_e            state_q, state_d;
  rfdd_pkg::cmd_t                   cmd_q, cmd_d;
  logic [rfdd_pkg::STAMP_W-1:0]     now_q, now_d;
  logic [rfdd_pkg::SLOT_COUNT-1:0]  valid_q, valid_d;
  logic [BW-1:0]                    next_q [rfdd_pkg::NODES];
  logic [BW-1:0]                    next_d [rfdd_pkg::NODES];
  logic [BW-1:0]                    slot_q, slot_d;
  logic                             out_vld_q, out_vld_d;
  logic                             discard_q, discard_d;
  logic                             bad_q, bad_d;

  logic                             row_re, row_we;
  logic [NW-1:0]                    row_raddr;
  logic [rfdd_pkg::ROW_W-1:0]       row_rdata, row_wdata;
  logic                             seen_re, seen_we;
  logic [SW-1:0]                    seen_addr;
  logic [rfdd_pkg::SEEN_W-1:0]      seen_rdata, seen_wdata;

  logic                             out_free;
  logic                             hit_any, hit_old;
  logic [BW-1:0]                    hit_idx;
  logic [rfdd_pkg::ENT_W-1:0]       hit_ent;
  logic [rfdd_pkg::STAMP_W-1:0]     age_diff;
  logic [rfdd_pkg::SEEN_IW-1:0]     bit_pos;
  logic [BW-1:0]                    next_cur;
  logic [SW-1:0]                    base_slot;

  assign out_free  = !out_vld_q || out_ready_i;
  assign next_cur  = next_q[cmd_q.node];
  assign bit_pos   = rfdd_pkg::SEEN_IW'({cmd_q.rec, cmd_q.bit_idx});
  assign base_slot = SW'(32'(cmd_q.node) * rfdd_pkg::MAX_BLOCKS);

  // tag match across the node row, first valid hit wins
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = rfdd_pkg::MAX_BLOCKS - 1; i >= 0; i--) begin
      if (valid_q[SW'(32'(base_slot) + i)] &&
          row_rdata[i*rfdd_pkg::ENT_W +: rfdd_pkg::TAG_W] == cmd_q.tag) begin
        hit_any = 1'b1;
        hit_idx = BW'(i);
      end
    end
  end

  // wrap-aware age test on the hit slot
  assign hit_ent  = row_rdata[32'(hit_idx)*rfdd_pkg::ENT_W +: rfdd_pkg::ENT_W];
  assign age_diff = hit_ent[rfdd_pkg::ENT_W-1:rfdd_pkg::TAG_W]
                    + rfdd_pkg::STAMP_W'(expiry_i) - now_q;
  assign hit_old  = age_diff[rfdd_pkg::STAMP_W-1];

  // datapath and memory controls
  always_comb begin
    cmd_d      = cmd_q;
    now_d      = now_q;
    valid_d    = valid_q;
    next_d     = next_q;
    slot_d     = slot_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    discard_d  = discard_q;
    bad_d      = bad_q;
    q_ready_o  = 1'b0;
    row_re     = 1'b0;
    row_we     = 1'b0;
    row_raddr  = q_cmd_i.node;
    row_wdata  = row_rdata;
    seen_re    = 1'b0;
    seen_we    = 1'b0;
    seen_addr  = SW'(32'(base_slot) + 32'(hit_idx));
    seen_wdata = seen_rdata;
    unique case (state_q)
      rfdd_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          unique case (q_cmd_i.kind)
            rfdd_pkg::CMD_CHECK: begin
              q_ready_o = 1'b1;
              row_re    = 1'b1;
              cmd_d     = q_cmd_i;
            end
            rfdd_pkg::CMD_TICK: begin
              if (out_free) begin
                q_ready_o = 1'b1;
                now_d     = now_q + 1'b1;
                out_vld_d = 1'b1;
                discard_d = 1'b0;
                bad_d     = 1'b0;
              end
            end
            rfdd_pkg::CMD_CLEAR: begin
              if (out_free) begin
                q_ready_o = 1'b1;
                for (int i = 0; i < rfdd_pkg::MAX_BLOCKS; i++) begin
                  valid_d[SW'(32'(q_cmd_i.node) * rfdd_pkg::MAX_BLOCKS + i)] = 1'b0;
                end
                next_d[q_cmd_i.node] = '0;
                out_vld_d = 1'b1;
                discard_d = 1'b0;
                bad_d     = 1'b0;
              end
            end
            rfdd_pkg::CMD_PASS: begin
              if (out_free) begin
                q_ready_o = 1'b1;
                out_vld_d = 1'b1;
                discard_d = q_cmd_i.discard;
                bad_d     = q_cmd_i.bad_port;
              end
            end
            default: ;
          endcase
        end
      end
      rfdd_pkg::BK_LOOK: begin
        if (hit_any && !hit_old) begin
          // live block: fetch its bit records
          seen_re = 1'b1;
          slot_d  = hit_idx;
        end else if (out_free) begin
          // missing or expired block takes the round-robin slot
          if (hit_any) begin
            valid_d[SW'(32'(base_slot) + 32'(hit_idx))] = 1'b0;
          end
          valid_d[SW'(32'(base_slot) + 32'(next_cur))] = 1'b1;
          row_we = 1'b1;
          row_wdata[32'(next_cur)*rfdd_pkg::ENT_W +: rfdd_pkg::ENT_W] = {now_q, cmd_q.tag};
          seen_we    = 1'b1;
          seen_addr  = SW'(32'(base_slot) + 32'(next_cur));
          seen_wdata = '0;
          seen_wdata[bit_pos] = 1'b1;
          next_d[cmd_q.node] = (32'(next_cur) == rfdd_pkg::MAX_BLOCKS - 1) ?
                               '0 : next_cur + 1'b1;
          out_vld_d = 1'b1;
          discard_d = 1'b0;
          bad_d     = 1'b0;
        end
      end
      rfdd_pkg::BK_BITS: begin
        seen_addr = SW'(32'(base_slot) + 32'(slot_q));
        if (out_free) begin
          // test and set the record bit
          seen_we             = 1'b1;
          seen_wdata[bit_pos] = 1'b1;
          out_vld_d = 1'b1;
          discard_d = seen_rdata[bit_pos];
          bad_d     = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rfdd_pkg::BK_IDLE: begin
        if (q_valid_i && q_cmd_i.kind == rfdd_pkg::CMD_CHECK) begin
          state_d = rfdd_pkg::BK_LOOK;
        end
      end
      rfdd_pkg::BK_LOOK: begin
        if (hit_any && !hit_old) begin
          state_d = rfdd_pkg::BK_BITS;
        end else if (out_free) begin
          state_d = rfdd_pkg::BK_IDLE;
        end
      end
      rfdd_pkg::BK_BITS: begin
        if (out_free) begin
          state_d = rfdd_pkg::BK_IDLE;
        end
      end
      default: state_d = rfdd_pkg::BK_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rfdd_pkg::BK_IDLE;
      now_q     <= '0;
      valid_q   <= '0;
      next_q    <= '{default: '0};
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      now_q     <= now_d;
      valid_q   <= valid_d;
      next_q    <= next_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    slot_q    <= slot_d;
    discard_q <= discard_d;
    bad_q     <= bad_d;
  end

  // block tags and stamps, one row per node
  rfdd_ram #(
    .Width (rfdd_pkg::ROW_W),
    .Depth (rfdd_pkg::NODES)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (cmd_q.node),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  // seen bit records, one row per slot
  rfdd_ram #(
    .Width (rfdd_pkg::SEEN_W),
    .Depth (rfdd_pkg::SLOT_COUNT)
  ) u_seen_ram (
    .clk_i   (clk_i),
    .we_i    (seen_we),
    .waddr_i (seen_addr),
    .wdata_i (seen_wdata),
    .re_i    (seen_re),
    .raddr_i (seen_addr),
    .rdata_o (seen_rdata)
  );

  assign out_valid_o = out_vld_q;
  assign discard_o   = discard_q;
  assign bad_port_o  = bad_q;

  `RFDD_ASSERT(a_look_is_check, state_q != rfdd_pkg::BK_LOOK || cmd_q.kind == rfdd_pkg::CMD_CHECK, "lookup without check command")
  `RFDD_ASSERT(a_pop_in_idle, !q_ready_o || state_q == rfdd_pkg::BK_IDLE, "queue popped while busy")
  `RFDD_ASSERT(a_flags_exclusive, !out_vld_q || !(discard_q && bad_q), "discard with bad port")
  `RFDD_ASSERT_NEXT(a_bits_after_read, state_q == rfdd_pkg::BK_LOOK && state_d == rfdd_pkg::BK_BITS, seen_addr == SW'(32'(base_slot) + 32'(slot_q)), "bit phase lost its slot")

endmodule
`default_nettype wire

// File: design/redundant_frame_duplicate_discard.sv
// path: tick, clear and pass-through beats pass the queue, then the registered output;
//   a check adds the tag row read (BK_LOOK) and, for a live block, the seen record read (BK_BITS)
// the back-end lookup sequencer works on one beat at a time (tag row read, then seen record
//   read-modify-write); the queue takes new beats while it is busy, until it is full
// reset: asynchronous active low, clears valid bits, round-robin pointers, time count
//   and the queue; no clearing pass, the block takes beats right after reset
`default_nettype none
module redundant_frame_duplicate_discard (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [2:0]  node_index_i,
  input  wire logic [15:0] sequence_nr_i,
  input  wire logic [1:0]  out_port_i,
  input  wire logic        rx_from_master_i,
  input  wire logic        out_is_master_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             discard_o,
  output logic             bad_port_o
);

  logic                         prp_mode_q;
  logic [rfdd_pkg::EXP_W-1:0]   expiry_q;
  logic                         cfg_we;
  rfdd_pkg::cmd_t               front_cmd, q_cmd;
  logic                         q_valid, q_ready;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prp_mode_q <= 1'b0;
      expiry_q   <= rfdd_pkg::EXPIRY_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        rfdd_pkg::REG_PRP_MODE: prp_mode_q <= pwdata[0];
        rfdd_pkg::REG_EXPIRY:   expiry_q   <= pwdata[rfdd_pkg::EXP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rfdd_pkg::REG_PRP_MODE: prdata = {31'b0, prp_mode_q};
      rfdd_pkg::REG_EXPIRY:   prdata = {16'b0, expiry_q};
      default:                prdata = '0;
    endcase
  end

  rfdd_front u_front (
    .prp_mode_i       (prp_mode_q),
    .func_i           (func_i),
    .node_index_i     (node_index_i),
    .sequence_nr_i    (sequence_nr_i),
    .out_port_i       (out_port_i),
    .rx_from_master_i (rx_from_master_i),
    .out_is_master_i  (out_is_master_i),
    .cmd_o            (front_cmd)
  );

  rfdd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_cmd_i    (front_cmd),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_cmd_o   (q_cmd)
  );

  rfdd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .expiry_i    (expiry_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_cmd_i     (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .discard_o   (discard_o),
    .bad_port_o  (bad_port_o)
  );

endmodule
`default_nettype wire
